// ----- design/assert_macros.svh -----
// Assertion macros of the greedy line breaker, included by its top-level RTL file.
// Plain SystemVerilog; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle
`define GLB_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define GLB_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`else

`define GLB_ASSERT_IMP(lbl, ant, cons, msg)
`define GLB_ASSERT_NEXT(lbl, ant, cons, msg)

`endif

`endif

// ----- design/glb_pkg.sv -----
// Shared types and constants of the greedy line breaker.
// No dependencies; imported by every module of the block.
`default_nettype none

package glb_pkg;

  localparam int MAX_TEXT_BYTES = 1048576;
  localparam int POS_W          = $clog2(MAX_TEXT_BYTES) + 1;
  localparam int ADV_W          = 24;
  localparam int WIDTH_W        = 32;
  localparam int KIND_W         = 2;
  localparam int TRAIL_W        = 3;
  localparam int SEP_W          = 3;
  localparam int CFG_IDX_W      = 1;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH   = 1'd1;

  // Break opportunity before a grapheme
  typedef enum logic [KIND_W-1:0] {
    BK_NONE      = 2'd0,
    BK_ALLOWED   = 2'd1,
    BK_MANDATORY = 2'd2
  } glb_kind_t;

  // One line record before content trimming
  typedef struct packed {
    logic [POS_W-1:0]   line_begin;
    logic [POS_W-1:0]   line_end;
    logic [POS_W-1:0]   next_start;
    logic               hard;
    logic [TRAIL_W-1:0] trail;
  } glb_rec_t;

  // All records caused by one word: one, or two when two is set
  typedef struct packed {
    logic     two;
    glb_rec_t rec0;
    glb_rec_t rec1;
  } glb_entry_t;

endpackage

`default_nettype wire

// ----- design/greedy_line_breaker.sv -----
// Greedy line breaker, top level: front end, entry queue and back end.
// Depends on glb_pkg, glb_front, glb_queue, glb_back and assert_macros.svh.
//
// The block takes one grapheme word per cycle while in_stall is low. The
// front end updates the paragraph state and decides all line records of a
// word in the cycle it is accepted, so words follow back to back. A word
// causes zero, one or two line records; the back end delivers one record per
// cycle while out_stall is low, from a four-entry queue into the output
// register, so a two-record word holds the output port for both in turn and
// a long run of such words is paced by the output. A record passes the queue
// and then the output register. in_stall rises only when the queue is full.
`default_nettype none
`include "assert_macros.svh"

module greedy_line_breaker import glb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [POS_W-1:0]     in_position,
  input  logic [ADV_W-1:0]     in_advance,
  input  logic [KIND_W-1:0]    in_break_kind,
  input  logic                 in_hanging_space,
  input  logic [TRAIL_W-1:0]   in_trail_separator_length,
  input  logic                 in_paragraph_start,
  input  logic                 in_paragraph_end,
  input  logic [SEP_W-1:0]     in_separator_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_W-1:0]     out_line_begin,
  output logic [POS_W-1:0]     out_content_end,
  output logic [POS_W-1:0]     out_next_start,
  output logic                 out_hard_break,
  output logic                 out_last
);

  logic       in_fire;
  logic       q_full, q_pop, q_head_valid, push_valid;
  glb_entry_t push_entry, q_head_entry;

  assign in_stall = q_full;
  assign in_fire  = in_valid && !q_full;

  glb_front u_front (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata),
    .in_fire                   (in_fire),
    .in_position               (in_position),
    .in_advance                (in_advance),
    .in_break_kind             (in_break_kind),
    .in_hanging_space          (in_hanging_space),
    .in_trail_separator_length (in_trail_separator_length),
    .in_paragraph_start        (in_paragraph_start),
    .in_paragraph_end          (in_paragraph_end),
    .in_separator_length       (in_separator_length),
    .push_valid                (push_valid),
    .push_entry                (push_entry)
  );

  glb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  glb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_entry      (q_head_entry),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_begin  (out_line_begin),
    .out_content_end (out_content_end),
    .out_next_start  (out_next_start),
    .out_hard_break  (out_hard_break),
    .out_last        (out_last)
  );

  // a terminator word always leaves an entry in the queue
  `GLB_ASSERT_NEXT(a_term_enqueued, in_fire && in_paragraph_end, q_head_valid, "terminator lost")
  // never pop an empty queue
  `GLB_ASSERT_IMP(a_pop_has_head, q_pop, q_head_valid, "pop from empty queue")
  // a free output with nothing queued goes idle
  `GLB_ASSERT_NEXT(a_out_idle, !out_stall && !q_head_valid, !out_valid, "stale output word")

endmodule

`default_nettype wire

// ----- design/glb_front.sv -----
// Front end: config registers, paragraph state and line-break decisions.
// Depends on glb_pkg; produces queue entries for glb_queue.
`default_nettype none

module glb_front import glb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_wdata,
  input  logic                 in_fire,
  input  logic [POS_W-1:0]     in_position,
  input  logic [ADV_W-1:0]     in_advance,
  input  logic [KIND_W-1:0]    in_break_kind,
  input  logic                 in_hanging_space,
  input  logic [TRAIL_W-1:0]   in_trail_separator_length,
  input  logic                 in_paragraph_start,
  input  logic                 in_paragraph_end,
  input  logic [SEP_W-1:0]     in_separator_length,
  output logic                 push_valid,
  output glb_entry_t           push_entry
);

  localparam int ADV_PAD = WIDTH_W + 1 - ADV_W;

  logic               wrap_en_r;
  logic [WIDTH_W-1:0] max_w_r;

  logic [POS_W-1:0]   ls_r, ls_nxt;
  logic [WIDTH_W-1:0] lw_r, lw_nxt;
  logic [POS_W-1:0]   lb_r, lb_nxt;
  logic [WIDTH_W-1:0] wab_r, wab_nxt;
  logic [WIDTH_W-1:0] rem_r, rem_nxt;   // line width past the last break, saturating
  logic [TRAIL_W-1:0] ptl_r, ptl_nxt;
  logic [TRAIL_W-1:0] tab_r, tab_nxt;

  logic [POS_W-1:0]   ls0, lb0, lb_a, pos_sep;
  logic [WIDTH_W-1:0] lw0, wab0, rem0, wab_a, lw_base;
  logic [TRAIL_W-1:0] ptl0, tab0, tab_a;
  logic [WIDTH_W:0]   adv_x, sum1, sum2, sum_f;
  logic               over1, over2, mand, allow, wrap_try;

  // Break decisions for one word
  always_comb begin
    ls0  = in_paragraph_start ? in_position : ls_r;
    lw0  = in_paragraph_start ? '0 : lw_r;
    lb0  = in_paragraph_start ? '0 : lb_r;
    wab0 = in_paragraph_start ? '0 : wab_r;
    rem0 = in_paragraph_start ? '0 : rem_r;
    ptl0 = in_paragraph_start ? '0 : ptl_r;
    tab0 = in_paragraph_start ? '0 : tab_r;

    adv_x   = {{ADV_PAD{1'b0}}, in_advance};
    sum1    = {1'b0, lw0} + adv_x;
    sum2    = {1'b0, rem0} + adv_x;
    over1   = sum1 > {1'b0, max_w_r};
    over2   = sum2 > {1'b0, max_w_r};
    pos_sep = in_position + {{(POS_W-SEP_W){1'b0}}, in_separator_length};

    mand  = (in_break_kind == BK_MANDATORY) && (in_position > ls0);
    allow = (in_break_kind == BK_ALLOWED) && (in_position > ls0);
    lb_a  = allow ? in_position : lb0;
    wab_a = allow ? lw0 : wab0;
    tab_a = allow ? ptl0 : tab0;
    wrap_try = wrap_en_r && !in_hanging_space && !mand && (in_position > ls0) && over1;

    push_valid = 1'b0;
    push_entry = '0;
    lw_base    = lw0;
    sum_f      = '0;

    ls_nxt  = ls0;
    lb_nxt  = lb_a;
    wab_nxt = wab_a;
    tab_nxt = tab_a;
    ptl_nxt = in_trail_separator_length;
    lw_nxt  = lw0;
    rem_nxt = rem0;

    if (in_paragraph_end) begin
      // terminator: one hard line, then clear the paragraph state
      push_valid = in_fire;
      push_entry.rec0 = '{line_begin: ls0, line_end: in_position, next_start: pos_sep,
                          hard: 1'b1, trail: ptl0};
      ls_nxt  = pos_sep;
      lw_nxt  = '0;
      lb_nxt  = '0;
      wab_nxt = '0;
      rem_nxt = '0;
      ptl_nxt = '0;
      tab_nxt = '0;
    end else begin
      if (mand) begin
        push_valid = in_fire;
        push_entry.rec0 = '{line_begin: ls0, line_end: in_position, next_start: in_position,
                            hard: 1'b1, trail: ptl0};
        ls_nxt  = in_position;
        lw_base = '0;
        lb_nxt  = '0;
      end else if (wrap_try) begin
        push_valid = in_fire;
        if (lb_a > ls0) begin
          // wrap back to the last allowed break
          push_entry.rec0 = '{line_begin: ls0, line_end: lb_a, next_start: lb_a,
                              hard: 1'b0, trail: tab_a};
          ls_nxt  = lb_a;
          lb_nxt  = '0;
          lw_base = allow ? '0 : rem0;
          // remainder may still overflow: emergency break before this grapheme
          if (!allow && (in_position > lb_a) && over2) begin
            push_entry.two  = 1'b1;
            push_entry.rec1 = '{line_begin: lb_a, line_end: in_position,
                                next_start: in_position, hard: 1'b0, trail: ptl0};
            ls_nxt  = in_position;
            lw_base = '0;
          end
        end else begin
          // no break inside the line: emergency break
          push_entry.rec0 = '{line_begin: ls0, line_end: in_position, next_start: in_position,
                              hard: 1'b0, trail: ptl0};
          ls_nxt  = in_position;
          lw_base = '0;
        end
      end
      // saturating width update and remainder past the break
      sum_f   = {1'b0, lw_base} + adv_x;
      lw_nxt  = sum_f[WIDTH_W] ? '1 : sum_f[WIDTH_W-1:0];
      rem_nxt = (lw_nxt >= wab_nxt) ? (lw_nxt - wab_nxt) : '0;
    end
  end

  // Config and paragraph state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_en_r <= 1'b0;
      max_w_r   <= '1;
      ls_r      <= '0;
      lw_r      <= '0;
      lb_r      <= '0;
      wab_r     <= '0;
      rem_r     <= '0;
      ptl_r     <= '0;
      tab_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WRAP_ENABLE: wrap_en_r <= cfg_wdata[0];
          CFG_MAX_WIDTH:   max_w_r   <= cfg_wdata;
          default:         ;
        endcase
      end
      if (in_fire) begin
        ls_r  <= ls_nxt;
        lw_r  <= lw_nxt;
        lb_r  <= lb_nxt;
        wab_r <= wab_nxt;
        rem_r <= rem_nxt;
        ptl_r <= ptl_nxt;
        tab_r <= tab_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/glb_queue.sv -----
// Short FIFO of line-record entries between front and back.
// Depends on glb_pkg for the entry type and depth.
`default_nettype none

module glb_queue import glb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  glb_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output glb_entry_t head_entry
);

  glb_entry_t        store_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == QDEPTH[QPTR_W:0]);
  assign head_valid = (count_r != '0);
  assign head_entry = store_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push_valid && !pop) count_nxt = count_r + 1'b1;
    if (!push_valid && pop) count_nxt = count_r - 1'b1;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)        rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (push_valid) store_r[wr_ptr_r] <= push_entry;
  end

endmodule

`default_nettype wire

// ----- design/glb_back.sv -----
// Back end: walks the records of each queue entry, trims trailing separators
// and holds the output register. Depends on glb_pkg.
`default_nettype none

module glb_back import glb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  glb_entry_t       head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [POS_W-1:0] out_line_begin,
  output logic [POS_W-1:0] out_content_end,
  output logic [POS_W-1:0] out_next_start,
  output logic             out_hard_break,
  output logic             out_last
);

  logic             out_valid_r;
  logic [POS_W-1:0] begin_r, content_r, next_r;
  logic             hard_r, last_r;
  logic             sel_r;

  glb_rec_t         rec;
  logic             load, is_last;
  logic [POS_W-1:0] room, trail_x, content;

  // pick the current record and trim its trailing separator
  always_comb begin
    load    = !out_valid_r || !out_stall;
    rec     = sel_r ? head_entry.rec1 : head_entry.rec0;
    is_last = !head_entry.two || sel_r;
    pop     = load && head_valid && is_last;
    room    = rec.line_end - rec.line_begin;
    trail_x = {{(POS_W-TRAIL_W){1'b0}}, rec.trail};
    content = rec.line_end;
    if (rec.line_end > rec.line_begin) begin
      content = (trail_x > room) ? rec.line_begin : (rec.line_end - trail_x);
    end
  end

  // output register and record select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) sel_r <= !is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      begin_r   <= rec.line_begin;
      content_r <= content;
      next_r    <= rec.next_start;
      hard_r    <= rec.hard;
      last_r    <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_begin  = begin_r;
  assign out_content_end = content_r;
  assign out_next_start  = next_r;
  assign out_hard_break  = hard_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for greedy_line_breaker: directed line-breaking cases, then
// random paragraphs under several idle and stall mixes, checked against a local predictor.
// Depends on glb_pkg and the greedy_line_breaker RTL only.
module tb;
  import glb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  // Break kind with no meaning; the block treats it as no opportunity
  localparam logic [KIND_W-1:0] BK_RESERVED = 2'd3;

  // One grapheme word as the input channel carries it
  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [ADV_W-1:0]   advance;
    logic [KIND_W-1:0]  kind;
    logic               hanging;
    logic [TRAIL_W-1:0] trail;
    logic               pstart;
    logic               pend;
    logic [SEP_W-1:0]   sep;
  } grapheme_t;

  // One line record as the result channel carries it
  typedef struct packed {
    logic [POS_W-1:0] line_begin;
    logic [POS_W-1:0] content_end;
    logic [POS_W-1:0] next_start;
    logic             hard;
    logic             last;
  } line_rec_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WRAP_ENABLE;
  logic [WIDTH_W-1:0]   cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [POS_W-1:0]     in_position = '0;
  logic [ADV_W-1:0]     in_advance = '0;
  logic [KIND_W-1:0]    in_break_kind = '0;
  logic                 in_hanging_space = 1'b0;
  logic [TRAIL_W-1:0]   in_trail_separator_length = '0;
  logic                 in_paragraph_start = 1'b0;
  logic                 in_paragraph_end = 1'b0;
  logic [SEP_W-1:0]     in_separator_length = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [POS_W-1:0]     out_line_begin;
  logic [POS_W-1:0]     out_content_end;
  logic [POS_W-1:0]     out_next_start;
  logic                 out_hard_break;
  logic                 out_last;

  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Line records still owed by the block, oldest first
  line_rec_t awaited_lines[$];

  // Predictor state: configuration and paragraph state
  logic               wrap_on;
  logic [WIDTH_W-1:0] width_limit;
  logic [POS_W-1:0]   line_origin;
  logic [WIDTH_W-1:0] run_width;
  logic [POS_W-1:0]   break_pos;
  logic [WIDTH_W-1:0] break_width;
  logic [TRAIL_W-1:0] prev_trail;
  logic [TRAIL_W-1:0] break_trail;
  line_rec_t          step_recs[3];
  int                 step_n;

  greedy_line_breaker u_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_position               (in_position),
    .in_advance                (in_advance),
    .in_break_kind             (in_break_kind),
    .in_hanging_space          (in_hanging_space),
    .in_trail_separator_length (in_trail_separator_length),
    .in_paragraph_start        (in_paragraph_start),
    .in_paragraph_end          (in_paragraph_end),
    .in_separator_length       (in_separator_length),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_line_begin            (out_line_begin),
    .out_content_end           (out_content_end),
    .out_next_start            (out_next_start),
    .out_hard_break            (out_hard_break),
    .out_last                  (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("greedy_line_breaker regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 50)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  function automatic void clear_paragraph();
    run_width   = '0;
    break_pos   = '0;
    break_width = '0;
    prev_trail  = '0;
    break_trail = '0;
  endfunction

  // Close the current line at end_pos; content is trimmed by the trailing separator
  function automatic void close_line(input logic [POS_W-1:0] end_pos, next_pos,
                                     input logic hard, input logic [TRAIL_W-1:0] trail);
    line_rec_t        rec;
    logic [POS_W-1:0] room;
    logic [POS_W-1:0] trail_ext;
    trail_ext       = {{(POS_W-TRAIL_W){1'b0}}, trail};
    rec.line_begin  = line_origin;
    rec.content_end = end_pos;
    if (end_pos > line_origin) begin
      room = end_pos - line_origin;
      rec.content_end = (trail_ext > room) ? line_origin : end_pos - trail_ext;
    end
    rec.next_start = next_pos;
    rec.hard       = hard;
    rec.last       = 1'b0;
    step_recs[step_n] = rec;
    step_n++;
    line_origin = next_pos;
  endfunction

  // Work out the line records caused by one accepted word
  function automatic void predict_lines(input grapheme_t g);
    logic [WIDTH_W:0] adv_ext;
    logic [WIDTH_W:0] total;
    line_rec_t        rec;
    logic [POS_W-1:0] sep_ext;
    adv_ext = {{(WIDTH_W+1-ADV_W){1'b0}}, g.advance};
    sep_ext = {{(POS_W-SEP_W){1'b0}}, g.sep};
    step_n  = 0;
    if (g.pstart) begin
      line_origin = g.position;
      clear_paragraph();
    end
    if (g.pend) begin
      close_line(g.position, g.position + sep_ext, 1'b1, prev_trail);
      clear_paragraph();
    end else begin
      if (g.kind == BK_MANDATORY && g.position > line_origin) begin
        close_line(g.position, g.position, 1'b1, prev_trail);
        run_width = '0;
        break_pos = '0;
      end
      if (g.kind == BK_ALLOWED && g.position > line_origin) begin
        break_pos   = g.position;
        break_width = run_width;
        break_trail = prev_trail;
      end
      // at most two wraps: back to the allowed break, then an emergency break
      if (wrap_on && !g.hanging) begin
        for (int round = 0; round < 2; round++) begin
          if (g.position > line_origin && {1'b0, run_width} + adv_ext > {1'b0, width_limit})
          begin
            if (break_pos > line_origin) begin
              close_line(break_pos, break_pos, 1'b0, break_trail);
              run_width = (run_width >= break_width) ? run_width - break_width : '0;
              break_pos = '0;
            end else begin
              close_line(g.position, g.position, 1'b0, prev_trail);
              run_width = '0;
            end
          end
        end
      end
      total = {1'b0, run_width} + adv_ext;
      run_width  = total[WIDTH_W] ? '1 : total[WIDTH_W-1:0];
      prev_trail = g.trail;
    end
    for (int i = 0; i < step_n; i++) begin
      rec      = step_recs[i];
      rec.last = (i == step_n - 1);
      awaited_lines = {awaited_lines, rec};
    end
  endfunction

  // Predict on each accepted word and register write; check each accepted line record
  always @(posedge clk) begin : line_monitor
    grapheme_t word;
    line_rec_t want;
    if (!rst_n) begin
      wrap_on     = 1'b0;
      width_limit = '1;
      line_origin = '0;
      clear_paragraph();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WRAP_ENABLE: wrap_on = cfg_wdata[0];
          CFG_MAX_WIDTH:   width_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        word = {in_position, in_advance, in_break_kind, in_hanging_space,
                in_trail_separator_length, in_paragraph_start, in_paragraph_end,
                in_separator_length};
        predict_lines(word);
      end
      if (out_valid && !out_stall) begin
        if (awaited_lines.size() == 0) begin
          report_mismatch("line record arrived with none awaited");
        end else begin
          want = awaited_lines.pop_front();
          if (out_line_begin !== want.line_begin)
            report_mismatch($sformatf("line_begin %h, want %h", out_line_begin,
                                      want.line_begin));
          if (out_content_end !== want.content_end)
            report_mismatch($sformatf("content_end %h, want %h", out_content_end,
                                      want.content_end));
          if (out_next_start !== want.next_start)
            report_mismatch($sformatf("next_start %h, want %h", out_next_start,
                                      want.next_start));
          if (out_hard_break !== want.hard)
            report_mismatch($sformatf("hard_break %b, want %b", out_hard_break, want.hard));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_last, want.last));
        end
      end
    end
  end

  function automatic grapheme_t make_grapheme(input logic [POS_W-1:0] pos,
                                              input logic [ADV_W-1:0] adv,
                                              input logic [KIND_W-1:0] kind,
                                              input logic hang,
                                              input logic [TRAIL_W-1:0] trail,
                                              input logic ps, pe,
                                              input logic [SEP_W-1:0] sep);
    grapheme_t g;
    g.position = pos;
    g.advance  = adv;
    g.kind     = kind;
    g.hanging  = hang;
    g.trail    = trail;
    g.pstart   = ps;
    g.pend     = pe;
    g.sep      = sep;
    return g;
  endfunction

  // Offer one word, with a random gap first, and hold it until taken
  task automatic send_grapheme(input grapheme_t g);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid                  <= 1'b1;
    in_position               <= g.position;
    in_advance                <= g.advance;
    in_break_kind             <= g.kind;
    in_hanging_space          <= g.hanging;
    in_trail_separator_length <= g.trail;
    in_paragraph_start        <= g.pstart;
    in_paragraph_end          <= g.pend;
    in_separator_length       <= g.sep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid, let the monitor see the last word, wait for every awaited record,
  // then let the pipeline empty
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers; only called with the block idle
  task automatic configure(input logic wrap, input logic [WIDTH_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WRAP_ENABLE;
    cfg_wdata <= WIDTH_W'(wrap);
    @(posedge clk);
    cfg_index <= CFG_MAX_WIDTH;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mandatory breaks, terminators, empty paragraph and separator trimming, no wrapping
  task automatic test_hard_breaks();
    settle_block();
    configure(1'b0, '1);
    send_grapheme(make_grapheme(0, 'h100, BK_NONE, 1'b0, 0, 1'b1, 1'b0, 0));
    send_grapheme(make_grapheme(1, 'h100, BK_ALLOWED, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(2, 'h80, BK_NONE, 1'b0, 1, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(4, 'h100, BK_MANDATORY, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(5, 'h100, BK_RESERVED, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(6, 0, BK_MANDATORY, 1'b0, 0, 1'b0, 1'b0, 0));
    // break at the line start is ignored
    send_grapheme(make_grapheme(6, 0, BK_MANDATORY, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(9, 0, BK_NONE, 1'b0, 0, 1'b0, 1'b1, 2));
    // empty paragraph
    send_grapheme(make_grapheme(20, 0, BK_NONE, 1'b0, 0, 1'b1, 1'b1, 1));
    // separator longer than the line
    send_grapheme(make_grapheme(30, 'h10, BK_NONE, 1'b0, 7, 1'b1, 1'b0, 0));
    send_grapheme(make_grapheme(31, 'h10, BK_MANDATORY, 1'b0, 4, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(35, 0, BK_NONE, 1'b0, 0, 1'b0, 1'b1, 0));
  endtask

  // Wrap to the allowed break, double wrap, emergency break, hanging space, tiny limit
  task automatic test_wrapping();
    settle_block();
    configure(1'b1, 'h200);
    send_grapheme(make_grapheme(0, 'h100, BK_NONE, 1'b0, 0, 1'b1, 1'b0, 0));
    send_grapheme(make_grapheme(1, 'h100, BK_ALLOWED, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(2, 'h200, BK_NONE, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(3, 'h300, BK_NONE, 1'b1, 1, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(4, 'h100, BK_ALLOWED, 1'b0, 2, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(6, 'h180, BK_ALLOWED, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(8, 0, BK_NONE, 1'b0, 0, 1'b0, 1'b1, 3));
    // first grapheme of a line never wraps
    send_grapheme(make_grapheme(10, 'h300, BK_NONE, 1'b0, 0, 1'b1, 1'b0, 0));
    send_grapheme(make_grapheme(11, 'h10, BK_NONE, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(12, 0, BK_NONE, 1'b0, 0, 1'b0, 1'b1, 0));
    settle_block();
    configure(1'b1, 1);
    send_grapheme(make_grapheme(20, 1, BK_NONE, 1'b0, 0, 1'b1, 1'b0, 0));
    send_grapheme(make_grapheme(21, 1, BK_NONE, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(22, 0, BK_NONE, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(23, 0, BK_NONE, 1'b0, 0, 1'b0, 1'b1, 0));
  endtask

  // Top of the position range, wrapping next start, backward positions, busy terminator
  task automatic test_extremes();
    settle_block();
    configure(1'b1, '1);
    send_grapheme(make_grapheme('h1FFFFE, '1, BK_ALLOWED, 1'b1, 7, 1'b1, 1'b0, 0));
    send_grapheme(make_grapheme('h1FFFFF, '1, BK_MANDATORY, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(5, '1, BK_MANDATORY, 1'b0, 3, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme('h1FFFFF, 0, BK_NONE, 1'b0, 0, 1'b0, 1'b1, 7));
    send_grapheme(make_grapheme(100, '1, BK_RESERVED, 1'b1, 7, 1'b0, 1'b1, 4));
    send_grapheme(make_grapheme(50, 'h10, BK_ALLOWED, 1'b0, 0, 1'b1, 1'b0, 0));
    send_grapheme(make_grapheme(40, 'h10, BK_MANDATORY, 1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(60, 0, BK_NONE, 1'b0, 0, 1'b0, 1'b1, 1));
  endtask

  // Full-scale advances against a large limit: wraps back to distant breaks
  task automatic test_wide_lines();
    settle_block();
    configure(1'b1, 'h0500_0000);
    send_grapheme(make_grapheme(0, '1, BK_NONE, 1'b0, 0, 1'b1, 1'b0, 0));
    for (int k = 1; k < 16; k++)
      send_grapheme(make_grapheme(POS_W'(k), '1, (k % 3 == 0) ? BK_ALLOWED : BK_NONE,
                                  1'b0, 0, 1'b0, 1'b0, 0));
    send_grapheme(make_grapheme(16, 0, BK_NONE, 1'b0, 0, 1'b0, 1'b1, 0));
  endtask

  function automatic logic [ADV_W-1:0] pick_advance(input logic [WIDTH_W-1:0] span);
    if ($urandom_range(19) == 0)
      return ADV_W'($urandom);
    return ADV_W'($urandom_range(span));
  endfunction

  // A well-formed paragraph with random content, sprinkled with noise words
  task automatic send_paragraph(input logic [WIDTH_W-1:0] span);
    grapheme_t        g;
    logic [63:0]      noise;
    logic [POS_W-1:0] pos;
    int unsigned      len;
    int unsigned      roll;
    if ($urandom_range(9) == 0)
      pos = POS_W'($urandom_range('h1FFFFF, 'h1FFF00));
    else
      pos = POS_W'($urandom_range('h1000));
    len = $urandom_range(12, 1);
    for (int k = 0; k < len; k++) begin
      noise = {$urandom, $urandom};
      if ($urandom_range(9) == 0) begin
        g = noise[$bits(grapheme_t)-1:0];
      end else begin
        g = '0;
        g.position = pos;
        g.advance  = pick_advance(span);
        roll = $urandom_range(99);
        if (roll < 45)      g.kind = BK_NONE;
        else if (roll < 85) g.kind = BK_ALLOWED;
        else if (roll < 95) g.kind = BK_MANDATORY;
        else                g.kind = BK_RESERVED;
        g.hanging = ($urandom_range(6) == 0);
        if ($urandom_range(6) == 0) g.trail = TRAIL_W'($urandom_range(7, 1));
        g.pstart = (k == 0) && ($urandom_range(9) != 0);
        g.sep    = SEP_W'($urandom);
        pos = pos + POS_W'($urandom_range(4, 1)) + POS_W'(g.trail);
      end
      send_grapheme(g);
    end
    // terminator, left out now and then
    if ($urandom_range(9) != 0) begin
      noise = {$urandom, $urandom};
      g = noise[$bits(grapheme_t)-1:0];
      g.pend     = 1'b1;
      g.pstart   = ($urandom_range(19) == 0);
      g.position = pos;
      g.sep      = ($urandom_range(9) == 0) ? SEP_W'($urandom_range(7))
                                            : SEP_W'($urandom_range(4));
      send_grapheme(g);
    end
  endtask

  // Random paragraphs over two random settings under one idle and stall mix
  task automatic test_random_traffic(input int unsigned idle_in, stall_out, quota);
    logic [WIDTH_W-1:0] limit;
    logic [WIDTH_W-1:0] span;
    int unsigned        goal;
    for (int setting = 0; setting < 2; setting++) begin
      settle_block();
      case ($urandom_range(3))
        0:       limit = 1;
        1:       limit = $urandom_range('h2000, 'h200);
        2:       limit = $urandom_range('h4000000, 'h10000);
        default: limit = '1;
      endcase
      configure($urandom_range(3) != 0, limit);
      span = limit / 3;
      if (span > 'hFFFFFF) span = 'hFFFFFF;
      if (span < 'h40) span = 'h40;
      send_idle_pct  = idle_in;
      sink_stall_pct = stall_out;
      goal = words_sent + quota / 2;
      while (words_sent < goal) send_paragraph(span);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hard_breaks();
    test_wrapping();
    test_extremes();
    test_wide_lines();
    test_random_traffic(0, 0, 24);
    test_random_traffic(47, 0, 24);
    test_random_traffic(0, 47, 24);
    test_random_traffic(24, 24, 24);
    settle_block();
    if (mismatches == 0)
      $display("greedy_line_breaker regression: pass");
    else
      $display("greedy_line_breaker regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/glb_pkg.sv
design/glb_front.sv
design/glb_queue.sv
design/glb_back.sv
design/greedy_line_breaker.sv
tb/tb.sv
